FILE: rtl/core/rvtrap_pkg.sv
// Shared types, event kinds, cause codes and status bit positions for the trap unit.
// Used by every module of the trap unit; depends on nothing else.
package rvtrap_pkg;

  localparam int XLEN = 64;

  localparam logic [3:0] KIND_POLL    = 4'd0;
  localparam logic [3:0] KIND_ECALL   = 4'd1;
  localparam logic [3:0] KIND_EBREAK  = 4'd2;
  localparam logic [3:0] KIND_PFAULT  = 4'd3;
  localparam logic [3:0] KIND_ILLEGAL = 4'd4;
  localparam logic [3:0] KIND_IRQ     = 4'd5;
  localparam logic [3:0] KIND_MRET    = 4'd6;
  localparam logic [3:0] KIND_SRET    = 4'd7;
  localparam logic [3:0] KIND_STATUS  = 4'd8;

  localparam logic [3:0] CAUSE_ILLEGAL   = 4'd2;
  localparam logic [3:0] CAUSE_BREAK     = 4'd3;
  localparam logic [3:0] CAUSE_ECALL_U   = 4'd8;
  localparam logic [3:0] CAUSE_ECALL_S   = 4'd9;
  localparam logic [3:0] CAUSE_ECALL_M   = 4'd11;
  localparam logic [3:0] CAUSE_LOAD_PF   = 4'd13;
  localparam logic [3:0] CAUSE_STORE_PF  = 4'd15;
  localparam logic [3:0] CAUSE_IRQ_MEXT  = 4'd11;
  localparam logic [3:0] CAUSE_IRQ_MTIM  = 4'd7;
  localparam logic [3:0] CAUSE_IRQ_MSOFT = 4'd3;
  localparam logic [3:0] CAUSE_IRQ_SEXT  = 4'd9;
  localparam logic [3:0] CAUSE_IRQ_STIM  = 4'd5;

  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam int ST_SIE  = 1;
  localparam int ST_MIE  = 3;
  localparam int ST_SPIE = 5;
  localparam int ST_MPIE = 7;
  localparam int ST_SPP  = 8;
  localparam int ST_MPP_LO = 11;
  localparam int ST_MPP_HI = 12;

  localparam logic [11:0] IRQ_LINES = 12'hAA8;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] pc;
    logic [63:0] fault_addr;
    logic        store_fault;
    logic [31:0] inst_word;
    logic [11:0] irq_pending;
    logic [11:0] irq_enable;
    logic [63:0] sepc_value;
    logic [63:0] status_value;
  } item_t;

  typedef struct packed {
    logic [XLEN-1:0] status;
    logic [1:0]      priv;
    logic [XLEN-1:0] saved_pc;
    logic [XLEN-1:0] saved_cause;
    logic [XLEN-1:0] saved_tval;
  } arch_t;

  typedef struct packed {
    logic        int_pending;
    logic        trap_taken;
    logic [3:0]  cause_code;
    logic        intr_cause;
    logic [63:0] next_pc;
    logic [1:0]  priv_out;
  } result_t;

endpackage

FILE: rtl/core/rvtrap_eval.sv
// Combinational event evaluation: next architectural state and the result of one event.
// Depends on rvtrap_pkg.
module rvtrap_eval (
  input  rvtrap_pkg::item_t   item,
  input  rvtrap_pkg::arch_t   arch,
  output rvtrap_pkg::arch_t   arch_next,
  output logic                trap_inc,
  output rvtrap_pkg::result_t result
);

  always_comb begin
    logic [11:0]            act_now;
    logic [11:0]            act_after;
    logic                   taken;
    logic                   intr;
    logic [3:0]             code;
    logic [rvtrap_pkg::XLEN-1:0] tval;
    logic [rvtrap_pkg::XLEN-1:0] st;
    logic [rvtrap_pkg::XLEN-1:0] cause_word;
    logic [63:0]            npc;

    act_now = arch.status[rvtrap_pkg::ST_MIE] ?
              (item.irq_pending & item.irq_enable & rvtrap_pkg::IRQ_LINES) : 12'd0;
    taken = 1'b0;
    intr  = 1'b0;
    code  = 4'd0;
    tval  = '0;
    npc   = 64'd0;
    st    = arch.status;
    cause_word = '0;
    arch_next = arch;

    case (item.kind)
      rvtrap_pkg::KIND_ECALL: begin
        taken = 1'b1;
        if (arch.priv == rvtrap_pkg::PRIV_USER) begin
          code = rvtrap_pkg::CAUSE_ECALL_U;
        end else if (arch.priv == rvtrap_pkg::PRIV_SUPER) begin
          code = rvtrap_pkg::CAUSE_ECALL_S;
        end else begin
          code = rvtrap_pkg::CAUSE_ECALL_M;
        end
      end
      rvtrap_pkg::KIND_EBREAK: begin
        taken = 1'b1;
        code  = rvtrap_pkg::CAUSE_BREAK;
      end
      rvtrap_pkg::KIND_PFAULT: begin
        taken = 1'b1;
        code  = item.store_fault ? rvtrap_pkg::CAUSE_STORE_PF : rvtrap_pkg::CAUSE_LOAD_PF;
        tval  = item.fault_addr[rvtrap_pkg::XLEN-1:0];
      end
      rvtrap_pkg::KIND_ILLEGAL: begin
        taken = 1'b1;
        code  = rvtrap_pkg::CAUSE_ILLEGAL;
        tval  = rvtrap_pkg::XLEN'(item.inst_word);
      end
      rvtrap_pkg::KIND_IRQ: begin
        if (act_now != 12'd0) begin
          taken = 1'b1;
          intr  = 1'b1;
        end
        if (act_now[11]) begin
          code = rvtrap_pkg::CAUSE_IRQ_MEXT;
        end else if (act_now[7]) begin
          code = rvtrap_pkg::CAUSE_IRQ_MTIM;
        end else if (act_now[3]) begin
          code = rvtrap_pkg::CAUSE_IRQ_MSOFT;
        end else if (act_now[9]) begin
          code = rvtrap_pkg::CAUSE_IRQ_SEXT;
        end else if (act_now[5]) begin
          code = rvtrap_pkg::CAUSE_IRQ_STIM;
        end
      end
      rvtrap_pkg::KIND_MRET: begin
        st = arch.status;
        st[rvtrap_pkg::ST_MIE]  = arch.status[rvtrap_pkg::ST_MPIE];
        st[rvtrap_pkg::ST_MPIE] = 1'b0;
        st[rvtrap_pkg::ST_MPP_HI:rvtrap_pkg::ST_MPP_LO] = 2'b00;
        arch_next.status = st;
        arch_next.priv   = arch.status[rvtrap_pkg::ST_MPP_HI:rvtrap_pkg::ST_MPP_LO];
        npc = 64'(arch.saved_pc);
      end
      rvtrap_pkg::KIND_SRET: begin
        st = arch.status;
        st[rvtrap_pkg::ST_SIE]  = arch.status[rvtrap_pkg::ST_SPIE];
        st[rvtrap_pkg::ST_SPIE] = 1'b0;
        st[rvtrap_pkg::ST_SPP]  = 1'b0;
        arch_next.status = st;
        arch_next.priv   = {1'b0, arch.status[rvtrap_pkg::ST_SPP]};
        npc = 64'(item.sepc_value[rvtrap_pkg::XLEN-1:0]);
      end
      rvtrap_pkg::KIND_STATUS: begin
        arch_next.status = item.status_value[rvtrap_pkg::XLEN-1:0];
      end
      default: begin
      end
    endcase

    if (taken) begin
      st = arch.status;
      st[rvtrap_pkg::ST_MIE]  = 1'b0;
      st[rvtrap_pkg::ST_MPIE] = arch.status[rvtrap_pkg::ST_MIE];
      st[rvtrap_pkg::ST_MPP_HI:rvtrap_pkg::ST_MPP_LO] = arch.priv;
      cause_word = '0;
      cause_word[3:0] = code;
      cause_word[rvtrap_pkg::XLEN-1] = intr;
      arch_next.status      = st;
      arch_next.priv        = rvtrap_pkg::PRIV_MACHINE;
      arch_next.saved_pc    = item.pc[rvtrap_pkg::XLEN-1:0];
      arch_next.saved_cause = cause_word;
      arch_next.saved_tval  = tval;
    end

    act_after = arch_next.status[rvtrap_pkg::ST_MIE] ?
                (item.irq_pending & item.irq_enable & rvtrap_pkg::IRQ_LINES) : 12'd0;

    trap_inc            = taken;
    result.int_pending  = (act_after != 12'd0);
    result.trap_taken   = taken;
    result.cause_code   = taken ? code : 4'd0;
    result.intr_cause   = intr;
    result.next_pc      = npc;
    result.priv_out     = arch_next.priv;
  end

endmodule

FILE: rtl/core/rvtrap_state.sv
// Architectural trap state registers and the trap counter.
// Depends on rvtrap_pkg.
module rvtrap_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  rvtrap_pkg::arch_t arch_next,
  input  logic              trap_inc,
  output rvtrap_pkg::arch_t arch
);

  logic [63:0] trap_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      arch.status      <= '0;
      arch.priv        <= rvtrap_pkg::PRIV_MACHINE;
      arch.saved_pc    <= '0;
      arch.saved_cause <= '0;
      arch.saved_tval  <= '0;
      trap_total       <= 64'd0;
    end else if (update) begin
      arch <= arch_next;
      if (trap_inc) begin
        trap_total <= trap_total + 64'd1;
      end
    end
  end

endmodule

FILE: rtl/core/riscv_trap_and_interrupt_unit.sv
// Top level of the trap unit: input register, event evaluation, state and result register.
// Depends on rvtrap_pkg, rvtrap_eval and rvtrap_state.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_stall    kind, pc, fault_addr, store_fault, inst_word,
//                                    irq_pending, irq_enable, sepc_value, status_value
//   out       out_valid / out_stall  int_pending, trap_taken, cause_code,
//                                    intr_cause, next_pc, priv_out
//
// One event per cycle while the result is not stalled; each event is captured in the input
// register, evaluated combinationally and its result captured in the result register.
// Reset is synchronous and returns the state to machine mode with all words cleared.
// A stalled result holds in the result register while the input register still takes
// one more event.
module riscv_trap_and_interrupt_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [63:0] pc,
  input  logic [63:0] fault_addr,
  input  logic        store_fault,
  input  logic [31:0] inst_word,
  input  logic [11:0] irq_pending,
  input  logic [11:0] irq_enable,
  input  logic [63:0] sepc_value,
  input  logic [63:0] status_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        int_pending,
  output logic        trap_taken,
  output logic [3:0]  cause_code,
  output logic        intr_cause,
  output logic [63:0] next_pc,
  output logic [1:0]  priv_out
);

  rvtrap_pkg::item_t   item;
  logic                item_valid;
  rvtrap_pkg::arch_t   arch;
  rvtrap_pkg::arch_t   arch_next;
  logic                trap_inc;
  rvtrap_pkg::result_t result;
  rvtrap_pkg::result_t result_reg;
  logic                advance;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{kind: kind, pc: pc, fault_addr: fault_addr, store_fault: store_fault,
                inst_word: inst_word, irq_pending: irq_pending, irq_enable: irq_enable,
                sepc_value: sepc_value, status_value: status_value};
    end
  end

  rvtrap_eval u_eval (
    .item      (item),
    .arch      (arch),
    .arch_next (arch_next),
    .trap_inc  (trap_inc),
    .result    (result)
  );

  rvtrap_state u_state (
    .clk       (clk),
    .rst       (rst),
    .update    (advance),
    .arch_next (arch_next),
    .trap_inc  (trap_inc),
    .arch      (arch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign int_pending  = result_reg.int_pending;
  assign trap_taken   = result_reg.trap_taken;
  assign cause_code   = result_reg.cause_code;
  assign intr_cause   = result_reg.intr_cause;
  assign next_pc      = result_reg.next_pc;
  assign priv_out     = result_reg.priv_out;

endmodule

FILE: rtl/core/rvtrap_checker.sv
// Port-level checks for the trap unit and the bind that attaches them to the top level.
// Depends on rvtrap_pkg and riscv_trap_and_interrupt_unit.
module rvtrap_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        int_pending,
  input logic        trap_taken,
  input logic [3:0]  cause_code,
  input logic        intr_cause,
  input logic [63:0] next_pc,
  input logic [1:0]  priv_out
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_trap_machine: assert property (@(posedge clk) disable iff (rst)
    (out_valid && trap_taken) |-> (priv_out == rvtrap_pkg::PRIV_MACHINE && !int_pending))
    else $error("trap did not enter machine mode with interrupts masked");

  a_intr_is_trap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !trap_taken) |-> (!intr_cause && cause_code == 4'd0))
    else $error("cause reported without a trap");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(next_pc) && $stable(cause_code)))
    else $error("stalled result changed");

endmodule

bind riscv_trap_and_interrupt_unit rvtrap_checker u_rvtrap_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .int_pending  (int_pending),
  .trap_taken   (trap_taken),
  .cause_code   (cause_code),
  .intr_cause   (intr_cause),
  .next_pc      (next_pc),
  .priv_out     (priv_out)
);

FILE: dv/tb_riscv_trap_and_interrupt_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for riscv_trap_and_interrupt_unit: directed and random events,
// checked in order against an in-bench model of the trap state. Depends on rvtrap_pkg.
module tb_riscv_trap_and_interrupt_unit;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  kind = '0;
  logic [63:0] pc = '0;
  logic [63:0] fault_addr = '0;
  logic        store_fault = 1'b0;
  logic [31:0] inst_word = '0;
  logic [11:0] irq_pending = '0;
  logic [11:0] irq_enable = '0;
  logic [63:0] sepc_value = '0;
  logic [63:0] status_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        int_pending;
  logic        trap_taken;
  logic [3:0]  cause_code;
  logic        intr_cause;
  logic [63:0] next_pc;
  logic [1:0]  priv_out;

  logic [rvtrap_pkg::XLEN-1:0] st_status = '0;
  logic [1:0]                  st_priv = rvtrap_pkg::PRIV_MACHINE;
  logic [rvtrap_pkg::XLEN-1:0] st_epc = '0;
  logic [rvtrap_pkg::XLEN-1:0] st_cause = '0;
  logic [rvtrap_pkg::XLEN-1:0] st_tval = '0;
  logic [63:0]                 st_traps = '0;

  rvtrap_pkg::result_t expected_q[$];
  rvtrap_pkg::result_t want;
  int send_idle = 16;
  int recv_idle = 48;
  int n_sent = 0;
  int n_checked = 0;
  int n_irq_traps = 0;
  int n_fail = 0;

  riscv_trap_and_interrupt_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .pc(pc), .fault_addr(fault_addr), .store_fault(store_fault),
    .inst_word(inst_word), .irq_pending(irq_pending), .irq_enable(irq_enable),
    .sepc_value(sepc_value), .status_value(status_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .int_pending(int_pending), .trap_taken(trap_taken), .cause_code(cause_code),
    .intr_cause(intr_cause), .next_pc(next_pc), .priv_out(priv_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void enter_trap(logic [3:0] code, logic intr, logic [63:0] epc,
                                     logic [63:0] tval);
    logic mie_was;
    mie_was = st_status[rvtrap_pkg::ST_MIE];
    st_epc = epc;
    st_cause = {intr, {(rvtrap_pkg::XLEN - 5){1'b0}}, code};
    st_tval = tval;
    st_status[rvtrap_pkg::ST_MPIE] = mie_was;
    st_status[rvtrap_pkg::ST_MIE] = 1'b0;
    st_status[rvtrap_pkg::ST_MPP_HI:rvtrap_pkg::ST_MPP_LO] = st_priv;
    st_priv = rvtrap_pkg::PRIV_MACHINE;
    st_traps = st_traps + 64'd1;
  endfunction

  function automatic logic [3:0] irq_cause(logic [11:0] live);
    if (live[rvtrap_pkg::CAUSE_IRQ_MEXT]) return rvtrap_pkg::CAUSE_IRQ_MEXT;
    if (live[rvtrap_pkg::CAUSE_IRQ_MTIM]) return rvtrap_pkg::CAUSE_IRQ_MTIM;
    if (live[rvtrap_pkg::CAUSE_IRQ_MSOFT]) return rvtrap_pkg::CAUSE_IRQ_MSOFT;
    if (live[rvtrap_pkg::CAUSE_IRQ_SEXT]) return rvtrap_pkg::CAUSE_IRQ_SEXT;
    return rvtrap_pkg::CAUSE_IRQ_STIM;
  endfunction

  function automatic rvtrap_pkg::result_t predict_event(rvtrap_pkg::item_t ev);
    rvtrap_pkg::result_t r;
    logic [11:0] live;
    logic [1:0] prev_mpp;
    logic spp;
    r = '0;
    live = ev.irq_pending & ev.irq_enable & rvtrap_pkg::IRQ_LINES;
    case (ev.kind)
      rvtrap_pkg::KIND_POLL: ;
      rvtrap_pkg::KIND_ECALL: begin
        r.cause_code = (st_priv == rvtrap_pkg::PRIV_USER) ? rvtrap_pkg::CAUSE_ECALL_U :
                       (st_priv == rvtrap_pkg::PRIV_SUPER) ? rvtrap_pkg::CAUSE_ECALL_S :
                       rvtrap_pkg::CAUSE_ECALL_M;
        r.trap_taken = 1'b1;
        enter_trap(r.cause_code, 1'b0, ev.pc, '0);
      end
      rvtrap_pkg::KIND_EBREAK: begin
        r.cause_code = rvtrap_pkg::CAUSE_BREAK;
        r.trap_taken = 1'b1;
        enter_trap(r.cause_code, 1'b0, ev.pc, '0);
      end
      rvtrap_pkg::KIND_PFAULT: begin
        r.cause_code = ev.store_fault ? rvtrap_pkg::CAUSE_STORE_PF : rvtrap_pkg::CAUSE_LOAD_PF;
        r.trap_taken = 1'b1;
        enter_trap(r.cause_code, 1'b0, ev.pc, ev.fault_addr);
      end
      rvtrap_pkg::KIND_ILLEGAL: begin
        r.cause_code = rvtrap_pkg::CAUSE_ILLEGAL;
        r.trap_taken = 1'b1;
        enter_trap(r.cause_code, 1'b0, ev.pc, {32'd0, ev.inst_word});
      end
      rvtrap_pkg::KIND_IRQ: begin
        if (st_status[rvtrap_pkg::ST_MIE] && live != '0) begin
          r.cause_code = irq_cause(live);
          r.trap_taken = 1'b1;
          r.intr_cause = 1'b1;
          enter_trap(r.cause_code, 1'b1, ev.pc, '0);
          n_irq_traps++;
        end
      end
      rvtrap_pkg::KIND_MRET: begin
        prev_mpp = st_status[rvtrap_pkg::ST_MPP_HI:rvtrap_pkg::ST_MPP_LO];
        st_status[rvtrap_pkg::ST_MIE] = st_status[rvtrap_pkg::ST_MPIE];
        st_status[rvtrap_pkg::ST_MPIE] = 1'b0;
        st_status[rvtrap_pkg::ST_MPP_HI:rvtrap_pkg::ST_MPP_LO] = 2'b00;
        st_priv = prev_mpp;
        r.next_pc = st_epc;
      end
      rvtrap_pkg::KIND_SRET: begin
        spp = st_status[rvtrap_pkg::ST_SPP];
        st_status[rvtrap_pkg::ST_SIE] = st_status[rvtrap_pkg::ST_SPIE];
        st_status[rvtrap_pkg::ST_SPIE] = 1'b0;
        st_status[rvtrap_pkg::ST_SPP] = 1'b0;
        st_priv = spp ? rvtrap_pkg::PRIV_SUPER : rvtrap_pkg::PRIV_USER;
        r.next_pc = ev.sepc_value;
      end
      rvtrap_pkg::KIND_STATUS: st_status = ev.status_value;
      default: ;
    endcase
    r.int_pending = st_status[rvtrap_pkg::ST_MIE] && live != '0;
    r.priv_out = st_priv;
    return r;
  endfunction

  function automatic rvtrap_pkg::item_t random_event();
    rvtrap_pkg::item_t ev;
    int pick;
    ev.kind = 4'($urandom);
    ev.pc = {$urandom, $urandom};
    ev.fault_addr = {$urandom, $urandom};
    ev.store_fault = 1'($urandom);
    ev.inst_word = $urandom;
    ev.irq_pending = 12'($urandom);
    ev.irq_enable = 12'($urandom);
    ev.sepc_value = {$urandom, $urandom};
    ev.status_value = {$urandom, $urandom};
    ev.status_value[rvtrap_pkg::ST_MIE] = ev.status_value[rvtrap_pkg::ST_MIE] | 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) ev.kind = rvtrap_pkg::KIND_POLL;
    else if (pick < 20) ev.kind = rvtrap_pkg::KIND_ECALL;
    else if (pick < 26) ev.kind = rvtrap_pkg::KIND_EBREAK;
    else if (pick < 36) ev.kind = rvtrap_pkg::KIND_PFAULT;
    else if (pick < 43) ev.kind = rvtrap_pkg::KIND_ILLEGAL;
    else if (pick < 63) ev.kind = rvtrap_pkg::KIND_IRQ;
    else if (pick < 73) ev.kind = rvtrap_pkg::KIND_MRET;
    else if (pick < 81) ev.kind = rvtrap_pkg::KIND_SRET;
    else if (pick < 95) ev.kind = rvtrap_pkg::KIND_STATUS;
    return ev;
  endfunction

  task automatic send_event(rvtrap_pkg::item_t ev);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= ev.kind;
    pc <= ev.pc;
    fault_addr <= ev.fault_addr;
    store_fault <= ev.store_fault;
    inst_word <= ev.inst_word;
    irq_pending <= ev.irq_pending;
    irq_enable <= ev.irq_enable;
    sepc_value <= ev.sepc_value;
    status_value <= ev.status_value;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_event(ev));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_kind(logic [3:0] k);
    rvtrap_pkg::item_t ev;
    ev = random_event();
    ev.kind = k;
    send_event(ev);
  endtask

  task automatic write_status(logic [63:0] value);
    rvtrap_pkg::item_t ev;
    ev = random_event();
    ev.kind = rvtrap_pkg::KIND_STATUS;
    ev.status_value = value;
    send_event(ev);
  endtask

  task automatic test_reset_poll();
    rvtrap_pkg::item_t ev;
    ev = random_event();
    ev.kind = rvtrap_pkg::KIND_POLL;
    ev.irq_pending = '1;
    ev.irq_enable = '1;
    send_event(ev);
  endtask

  task automatic test_exceptions();
    rvtrap_pkg::item_t ev;
    ev = random_event();
    ev.kind = rvtrap_pkg::KIND_ECALL;
    ev.pc = '1;
    send_event(ev);
    ev = random_event();
    ev.kind = rvtrap_pkg::KIND_EBREAK;
    ev.pc = '0;
    send_event(ev);
    ev = random_event();
    ev.kind = rvtrap_pkg::KIND_PFAULT;
    ev.store_fault = 1'b0;
    ev.fault_addr = '1;
    send_event(ev);
    ev.store_fault = 1'b1;
    ev.fault_addr = '0;
    send_event(ev);
    ev = random_event();
    ev.kind = rvtrap_pkg::KIND_ILLEGAL;
    ev.inst_word = '1;
    send_event(ev);
  endtask

  task automatic test_returns();
    write_status((64'd1 << rvtrap_pkg::ST_MPIE) | (64'd1 << rvtrap_pkg::ST_SPIE) |
                 (64'd1 << rvtrap_pkg::ST_SPP));
    send_kind(rvtrap_pkg::KIND_MRET);
    send_kind(rvtrap_pkg::KIND_ECALL);
    send_kind(rvtrap_pkg::KIND_SRET);
    send_kind(rvtrap_pkg::KIND_ECALL);
    send_kind(rvtrap_pkg::KIND_SRET);
  endtask

  task automatic test_interrupt_priority();
    logic [3:0] order[5] = '{rvtrap_pkg::CAUSE_IRQ_MEXT, rvtrap_pkg::CAUSE_IRQ_MTIM,
                             rvtrap_pkg::CAUSE_IRQ_MSOFT, rvtrap_pkg::CAUSE_IRQ_SEXT,
                             rvtrap_pkg::CAUSE_IRQ_STIM};
    logic [11:0] lines;
    rvtrap_pkg::item_t ev;
    for (int i = 0; i < 5; i++) begin
      lines = '0;
      for (int j = i; j < 5; j++) lines[order[j]] = 1'b1;
      write_status(64'd1 << rvtrap_pkg::ST_MIE);
      ev = random_event();
      ev.kind = rvtrap_pkg::KIND_IRQ;
      ev.irq_pending = lines;
      ev.irq_enable = '1;
      send_event(ev);
    end
    // Global enable is now clear, so a fully pending request is not taken.
    ev.irq_pending = '1;
    send_event(ev);
    write_status(64'd1 << rvtrap_pkg::ST_MIE);
    ev.irq_enable = ~rvtrap_pkg::IRQ_LINES;
    send_event(ev);
  endtask

  task automatic test_reserved_privilege();
    write_status(64'd2 << rvtrap_pkg::ST_MPP_LO);
    send_kind(rvtrap_pkg::KIND_MRET);
    send_kind(rvtrap_pkg::KIND_ECALL);
    send_kind(rvtrap_pkg::KIND_MRET);
  endtask

  task automatic test_unused_kinds();
    send_kind(rvtrap_pkg::KIND_STATUS + 4'd1);
    send_kind(4'hF);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_event(random_event());
  endtask

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
      n_fail++;
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        n_fail++;
      end else begin
        want = expected_q.pop_front();
        check_field("int_pending", 64'(want.int_pending), 64'(int_pending));
        check_field("trap_taken", 64'(want.trap_taken), 64'(trap_taken));
        check_field("cause_code", 64'(want.cause_code), 64'(cause_code));
        check_field("intr_cause", 64'(want.intr_cause), 64'(intr_cause));
        check_field("next_pc", want.next_pc, next_pc);
        check_field("priv_out", 64'(want.priv_out), 64'(priv_out));
        n_checked++;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_reset_poll();
    test_exceptions();
    test_returns();
    test_interrupt_priority();
    test_reserved_privilege();
    test_unused_kinds();
    test_random(640);
    send_idle = 48;
    recv_idle = 16;
    test_random(640);
    send_idle = 0;
    recv_idle = 0;
    test_random(640);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d events and checked %0d results under three idle patterns.",
             n_sent, n_checked);
    $display("The model took %0d traps, %0d of them interrupts.", st_traps, n_irq_traps);
    if (n_fail == 0) begin
      $display("** riscv_trap_and_interrupt_unit: PASSED **");
    end else begin
      $display("** riscv_trap_and_interrupt_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results still expected.", expected_q.size());
    $display("** riscv_trap_and_interrupt_unit: FAILED **");
    $finish;
  end

endmodule
